>>> rtl/bup_pkg.sv
`default_nettype none

package bup_pkg;

  // request kinds carried in the input tuser
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_PIXEL  = 2'd1;
  localparam logic [1:0] REQ_REPLAY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_SCALE    = 3'd4;

  // display command bytes
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // rgb565 to rgb666 byte masks
  localparam logic [7:0] RED_MASK   = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;
  localparam logic [7:0] BLUE_MASK  = 8'hFF;

  // clamp limits
  localparam logic [9:0] MAX_HEIGHT = 10'd512;
  localparam logic [3:0] MAX_SCALE  = 4'd8;

  // byte index of the final byte of the window set-up sequence
  localparam logic [4:0] START_LAST = 5'd10;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_PIXEL,
    JOB_REPLAY
  } job_kind_t;

  // work handed from the request front end to the byte sequencer
  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] pix;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [13:0] span_x;
    logic [13:0] span_y;
    logic [3:0]  scale;
    logic        done;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/bup_line_store.sv
`default_nettype none

module bup_line_store #(
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [15:0]        rd_data
);

  logic [15:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // one registered read port, output holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bup_ctrl.sv
`default_nettype none

module bup_ctrl
  import bup_pkg::*;
#(
  parameter int MAX_WIDTH = 512,
  parameter int AW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // configuration writes
  input  wire logic          cfg_valid,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  // incoming requests
  input  wire logic          req_valid,
  input  wire logic [1:0]    req_type,
  input  wire logic [15:0]   req_pixel,
  output logic               req_ready,
  // job slot toward the sequencer
  input  wire logic          job_take,
  output logic               job_valid,
  output job_t               job,
  // line store access
  output logic               mem_wr_en,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_addr,
  output logic [15:0]        mem_wr_data
);

  localparam int CMPW = 14;

  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [9:0]  src_width;
  logic [9:0]  src_height;
  logic [3:0]  scale_factor;

  logic [AW-1:0] column_count;
  logic [8:0]    row_count;
  logic [2:0]    repeat_count;
  logic          frame_active;

  logic [9:0]  w_eff;
  logic [9:0]  h_eff;
  logic [3:0]  s_eff;
  logic [AW:0] col_inc;
  logic [9:0]  row_inc;
  logic [3:0]  rep_inc;
  logic        accept;
  logic        is_start;
  logic        is_pixel;
  logic        is_replay;
  logic        col_wrap;
  logic        rep_wrap;
  logic        row_wrap;

  // clamp the geometry registers to their legal ranges
  always_comb begin
    if (src_width == 10'd0) begin
      w_eff = 10'd1;
    end else if ({4'd0, src_width} > CMPW'(MAX_WIDTH)) begin
      w_eff = 10'(MAX_WIDTH);
    end else begin
      w_eff = src_width;
    end
    if (src_height == 10'd0) begin
      h_eff = 10'd1;
    end else if (src_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = src_height;
    end
    if (scale_factor == 4'd0) begin
      s_eff = 4'd1;
    end else if (scale_factor > MAX_SCALE) begin
      s_eff = MAX_SCALE;
    end else begin
      s_eff = scale_factor;
    end
  end

  // request decode
  assign req_ready = !job_valid || job_take;
  assign accept    = req_valid && req_ready;
  assign is_start  = accept && (req_type == REQ_START);
  assign is_pixel  = accept && frame_active && (req_type == REQ_PIXEL)
                     && (repeat_count == 3'd0);
  assign is_replay = accept && frame_active && (req_type == REQ_REPLAY)
                     && (repeat_count != 3'd0);

  // position advance
  assign col_inc  = {1'b0, column_count} + 1'b1;
  assign row_inc  = {1'b0, row_count} + 1'b1;
  assign rep_inc  = {1'b0, repeat_count} + 1'b1;
  assign col_wrap = CMPW'(col_inc) >= CMPW'(w_eff);
  assign rep_wrap = rep_inc >= s_eff;
  assign row_wrap = row_inc >= h_eff;

  // line store port
  assign mem_wr_en   = is_pixel;
  assign mem_rd_en   = is_replay;
  assign mem_addr    = column_count;
  assign mem_wr_data = req_pixel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= 16'd0;
      origin_y     <= 16'd0;
      src_width    <= 10'd1;
      src_height   <= 10'd1;
      scale_factor <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x     <= cfg_data;
        CFG_ORIGIN_Y: origin_y     <= cfg_data;
        CFG_WIDTH:    src_width    <= cfg_data[9:0];
        CFG_HEIGHT:   src_height   <= cfg_data[9:0];
        CFG_SCALE:    scale_factor <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // frame position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= 9'd0;
      repeat_count <= 3'd0;
      frame_active <= 1'b0;
    end else if (is_start) begin
      column_count <= '0;
      row_count    <= 9'd0;
      repeat_count <= 3'd0;
      frame_active <= 1'b1;
    end else if (is_pixel || is_replay) begin
      if (col_wrap) begin
        column_count <= '0;
        if (rep_wrap) begin
          repeat_count <= 3'd0;
          if (row_wrap) begin
            row_count    <= 9'd0;
            frame_active <= 1'b0;
          end else begin
            row_count <= row_inc[8:0];
          end
        end else begin
          repeat_count <= rep_inc[2:0];
        end
      end else begin
        column_count <= col_inc[AW-1:0];
      end
    end
  end

  // job slot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (is_start || is_pixel || is_replay) begin
      job_valid <= 1'b1;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  // job payload, window spans multiplied here and registered
  always_ff @(posedge clk) begin
    if (is_start || is_pixel || is_replay) begin
      job.kind     <= is_start ? JOB_START : (is_pixel ? JOB_PIXEL : JOB_REPLAY);
      job.pix      <= req_pixel;
      job.origin_x <= origin_x;
      job.origin_y <= origin_y;
      job.span_x   <= 14'(w_eff) * 14'(s_eff);
      job.span_y   <= 14'(h_eff) * 14'(s_eff);
      job.scale    <= s_eff;
      job.done     <= !is_start && col_wrap && rep_wrap && row_wrap;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bup_emit.sv
`default_nettype none

module bup_emit
  import bup_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // job slot from the front end
  input  wire logic        job_valid,
  input  wire job_t        job,
  output logic             job_take,
  // line store read data for replays
  input  wire logic [15:0] rd_data,
  // output byte register
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_is_data,
  output logic             out_last,
  output logic             out_done
);

  logic        busy;
  job_kind_t   kind;
  logic [15:0] pix;
  logic [15:0] x1;
  logic [15:0] x2;
  logic [15:0] y1;
  logic [15:0] y2;
  logic        done;
  logic [4:0]  idx;
  logic [1:0]  phase;
  logic [4:0]  last_idx;

  logic        adv;
  logic        is_last;
  logic [7:0]  byte_next;
  logic        data_next;
  logic [15:0] wx2;
  logic [15:0] wy2;

  assign adv      = busy && (!out_valid || out_ready);
  assign is_last  = idx == last_idx;
  assign job_take = job_valid && (!busy || (adv && is_last));

  // window end points
  assign wx2 = job.origin_x + 16'(job.span_x) - 16'd1;
  assign wy2 = job.origin_y + 16'(job.span_y);

  // byte selection
  always_comb begin
    byte_next = CMD_MEMORY_WRITE;
    data_next = 1'b1;
    if (kind == JOB_START) begin
      unique case (idx)
        5'd0: begin
          byte_next = CMD_COLUMN_SET;
          data_next = 1'b0;
        end
        5'd1: byte_next = x1[15:8];
        5'd2: byte_next = x1[7:0];
        5'd3: byte_next = x2[15:8];
        5'd4: byte_next = x2[7:0];
        5'd5: begin
          byte_next = CMD_PAGE_SET;
          data_next = 1'b0;
        end
        5'd6: byte_next = y1[15:8];
        5'd7: byte_next = y1[7:0];
        5'd8: byte_next = y2[15:8];
        5'd9: byte_next = y2[7:0];
        default: begin
          byte_next = CMD_MEMORY_WRITE;
          data_next = 1'b0;
        end
      endcase
    end else begin
      case (phase)
        2'd0:    byte_next = pix[15:8] & RED_MASK;
        2'd1:    byte_next = pix[10:3] & GREEN_MASK;
        default: byte_next = {pix[4:0], 3'd0} & BLUE_MASK;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_take) begin
      busy <= 1'b1;
    end else if (adv && is_last) begin
      busy <= 1'b0;
    end
  end

  // job load and byte position
  always_ff @(posedge clk) begin
    if (job_take) begin
      kind  <= job.kind;
      pix   <= (job.kind == JOB_REPLAY) ? rd_data : job.pix;
      done  <= job.done;
      idx   <= 5'd0;
      phase <= 2'd0;
      if (wx2 < job.origin_x) begin
        x1 <= wx2;
        x2 <= job.origin_x;
      end else begin
        x1 <= job.origin_x;
        x2 <= wx2;
      end
      if (wy2 < job.origin_y) begin
        y1 <= wy2;
        y2 <= job.origin_y;
      end else begin
        y1 <= job.origin_y;
        y2 <= wy2;
      end
      if (job.kind == JOB_START) begin
        last_idx <= START_LAST;
      end else begin
        last_idx <= {1'b0, job.scale} + {job.scale, 1'b0} - 5'd1;
      end
    end else if (adv) begin
      idx   <= idx + 5'd1;
      phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte    <= byte_next;
      out_is_data <= data_next;
      out_last    <= is_last;
      out_done    <= is_last && done && (kind != JOB_START);
    end
  end

endmodule

`default_nettype wire

>>> rtl/bitmap_upscale_rgb666_stream.sv
`default_nettype none

// Nearest-neighbour bitmap upscaler for an RGB666 byte-serial display link.
// A start request emits the 11-byte window set-up (column-set, start/end
// column, page-set, start/end page, memory-write). A pixel request stores its
// RGB565 value in the line store and emits it scale_factor times as three
// RGB666 bytes; a replay request resends the next stored pixel for the
// repeated rows. Both emit 3*scale_factor bytes (3 to 24) from the byte
// sequencer, one byte per cycle unless the output stalls. Out-of-sequence
// requests are accepted and produce nothing. Requests are taken while the
// previous one is still being sent; the next job waits in a one-entry slot
// and follows the last byte of the current one without a gap. Configuration
// must only be written while the block is idle. The line store has no reset.
module bitmap_upscale_rgb666_stream
  import bup_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] pixel
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  // byte stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]       m_axis_tuser,  // [0] is_data, [1] frame_done
  output logic             m_axis_tlast   // last_of_run
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic          job_valid;
  logic          job_take;
  job_t          job;
  logic          mem_wr_en;
  logic          mem_rd_en;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wr_data;
  logic [15:0]   mem_rd_data;
  logic          out_is_data;
  logic          out_done;

  assign cfg_ready    = 1'b1;
  assign m_axis_tuser = {out_done, out_is_data};

  // request front end and frame counters
  bup_ctrl #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(s_axis_tvalid),
    .req_type(s_axis_tuser),
    .req_pixel(s_axis_tdata),
    .req_ready(s_axis_tready),
    .job_take(job_take),
    .job_valid(job_valid),
    .job(job),
    .mem_wr_en(mem_wr_en),
    .mem_rd_en(mem_rd_en),
    .mem_addr(mem_addr),
    .mem_wr_data(mem_wr_data)
  );

  // source line store
  bup_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .wr_en(mem_wr_en),
    .wr_addr(mem_addr),
    .wr_data(mem_wr_data),
    .rd_en(mem_rd_en),
    .rd_addr(mem_addr),
    .rd_data(mem_rd_data)
  );

  // byte sequencer and output register
  bup_emit u_emit (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job(job),
    .job_take(job_take),
    .rd_data(mem_rd_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_byte(m_axis_tdata),
    .out_is_data(out_is_data),
    .out_last(m_axis_tlast),
    .out_done(out_done)
  );

endmodule

`default_nettype wire

>>> rtl/bup_checker.sv
`default_nettype none

module bup_checker
  import bup_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // nothing offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a stalled byte stays offered unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output byte changed");

  // frame end only on the last data byte of a request
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tuser[0])
    else $error("frame done without last data byte");

  // a command byte that ends a request is the memory-write command
  a_cmd_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0]
      |-> m_axis_tdata == CMD_MEMORY_WRITE)
    else $error("set-up sequence ends on wrong command");

endmodule

bind bitmap_upscale_rgb666_stream bup_checker u_checker (
  .clk(clk),
  .rst(rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);

`default_nettype wire

>>> verif/link_byte_checker.sv
`timescale 1ns / 100ps

module link_byte_checker
  import bup_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] pixel
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  input  wire logic [1:0]  m_axis_tuser,  // [0] is_data, [1] frame_done
  input  wire logic        m_axis_tlast,
  output int               mismatch_count,
  output int               bytes_due
);

  typedef struct packed {
    logic [7:0] octet;
    logic       is_data;
    logic       last;
    logic       done;
  } link_byte_t;

  // bytes still owed by the block, oldest first
  link_byte_t  due_q[$];
  link_byte_t  head;
  link_byte_t  seen;

  // own copy of the line store, counters and registers
  logic [15:0] row_buf [MAX_WIDTH];
  logic [15:0] org_x;
  logic [15:0] org_y;
  logic [9:0]  width_reg;
  logic [9:0]  height_reg;
  logic [3:0]  scale_reg;
  int          col_idx;
  int          row_idx;
  int          rep_idx;
  bit          in_frame;
  int          errs = 0;

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic d, input logic l,
                            input logic f);
    due_q.push_back('{b, d, l, f});
  endtask

  // bytes caused by one accepted request, with the counter update
  task automatic predict_link_bytes(input logic [1:0] kind, input logic [15:0] pix);
    int          w;
    int          h;
    int          s;
    int          i;
    logic [15:0] x1;
    logic [15:0] x2;
    logic [15:0] y1;
    logic [15:0] y2;
    logic [15:0] t;
    logic [15:0] p;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    bit          done;
    w = clamp_to(int'(width_reg), MAX_WIDTH);
    h = clamp_to(int'(height_reg), int'(MAX_HEIGHT));
    s = clamp_to(int'(scale_reg), int'(MAX_SCALE));
    done = 1'b0;

    // window set-up sequence, ends out of order are swapped
    if (kind == REQ_START) begin
      x1 = org_x;
      x2 = 16'(int'(org_x) + w * s - 1);
      y1 = org_y;
      y2 = 16'(int'(org_y) + h * s);
      if (x2 < x1) begin
        t = x1; x1 = x2; x2 = t;
      end
      if (y2 < y1) begin
        t = y1; y1 = y2; y2 = t;
      end
      queue_byte(CMD_COLUMN_SET, 1'b0, 1'b0, 1'b0);
      queue_byte(x1[15:8], 1'b1, 1'b0, 1'b0);
      queue_byte(x1[7:0], 1'b1, 1'b0, 1'b0);
      queue_byte(x2[15:8], 1'b1, 1'b0, 1'b0);
      queue_byte(x2[7:0], 1'b1, 1'b0, 1'b0);
      queue_byte(CMD_PAGE_SET, 1'b0, 1'b0, 1'b0);
      queue_byte(y1[15:8], 1'b1, 1'b0, 1'b0);
      queue_byte(y1[7:0], 1'b1, 1'b0, 1'b0);
      queue_byte(y2[15:8], 1'b1, 1'b0, 1'b0);
      queue_byte(y2[7:0], 1'b1, 1'b0, 1'b0);
      queue_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
      col_idx = 0;
      row_idx = 0;
      rep_idx = 0;
      in_frame = 1'b1;
      return;
    end

    // out-of-sequence requests leave everything as it was
    if (!in_frame || (kind != REQ_PIXEL && kind != REQ_REPLAY)) return;
    if (kind == REQ_PIXEL) begin
      if (rep_idx != 0) return;
      if (col_idx >= MAX_WIDTH) col_idx = 0;
      row_buf[col_idx] = pix;
      p = pix;
    end else begin
      if (rep_idx == 0) return;
      if (col_idx >= MAX_WIDTH) col_idx = 0;
      p = row_buf[col_idx];
    end

    // advance column, repeat pass and row
    col_idx++;
    if (col_idx >= w) begin
      col_idx = 0;
      rep_idx++;
      if (rep_idx >= s) begin
        rep_idx = 0;
        row_idx++;
        if (row_idx >= h) begin
          row_idx = 0;
          in_frame = 1'b0;
          done = 1'b1;
        end
      end
    end

    // rgb565 to three rgb666 bytes, repeated scale times
    red   = 8'(p >> 8) & RED_MASK;
    green = 8'(p >> 3) & GREEN_MASK;
    blue  = 8'(p << 3) & BLUE_MASK;
    for (i = 0; i < s; i++) begin
      queue_byte(red, 1'b1, 1'b0, 1'b0);
      queue_byte(green, 1'b1, 1'b0, 1'b0);
      queue_byte(blue, 1'b1, 1'(i == s - 1), 1'(done && i == s - 1));
    end
  endtask

  // watch all three channels; predict before comparing
  always @(posedge clk) begin
    if (rst) begin
      org_x = '0;
      org_y = '0;
      width_reg = 10'd1;
      height_reg = 10'd1;
      scale_reg = 4'd1;
      col_idx = 0;
      row_idx = 0;
      rep_idx = 0;
      in_frame = 1'b0;
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X: org_x = cfg_data;
          CFG_ORIGIN_Y: org_y = cfg_data;
          CFG_WIDTH:    width_reg = cfg_data[9:0];
          CFG_HEIGHT:   height_reg = cfg_data[9:0];
          CFG_SCALE:    scale_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_link_bytes(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
        if (due_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected byte %02h dc %0d last %0d done %0d", $realtime,
                     seen.octet, seen.is_data, seen.last, seen.done);
        end else begin
          head = due_q.pop_front();
          if (seen !== head) begin
            errs++;
            if (errs <= 10)
              $display("%0t: byte mismatch: expected %02h dc %0d last %0d done %0d,",
                       $realtime, head.octet, head.is_data, head.last, head.done,
                       " got %02h dc %0d last %0d done %0d",
                       seen.octet, seen.is_data, seen.last, seen.done);
          end
        end
      end
    end
    mismatch_count <= errs;
    bytes_due <= due_q.size();
  end

endmodule

>>> verif/bitmap_upscale_rgb666_stream_tb.sv
`timescale 1ns / 100ps

module bitmap_upscale_rgb666_stream_tb;
  import bup_pkg::*;

  localparam int MAX_WIDTH = 512;
  localparam int RAND_ITEMS = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_OFF = 300;
  localparam int SETTLE = 30;
  localparam int DRAIN = 40;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [15:0] s_data = '0;  // [15:0] pixel
  logic [1:0]  s_user = '0;  // [1:0] req_type
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;       // [7:0] out_byte
  logic [1:0]  m_user;       // [0] is_data, [1] frame_done
  logic        m_last;
  int          mismatch_count;
  int          bytes_due;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          frame_items = 0;
  bit          squeeze = 1'b0;

  // register values last written, used to shape well-formed frames
  logic [9:0]  sh_w = 10'd1;
  logic [9:0]  sh_h = 10'd1;
  logic [3:0]  sh_s = 4'd1;

  bitmap_upscale_rgb666_stream #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata(s_data),
    .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata(m_data),
    .m_axis_tuser(m_user),
    .m_axis_tlast(m_last)
  );

  link_byte_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata(s_data),
    .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata(m_data),
    .m_axis_tuser(m_user),
    .m_axis_tlast(m_last),
    .mismatch_count(mismatch_count),
    .bytes_due(bytes_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register write; valid stays up so writes can follow back to back
  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WIDTH:  sh_w = val[9:0];
      CFG_HEIGHT: sh_h = val[9:0];
      CFG_SCALE:  sh_s = val[3:0];
      default: ;
    endcase
  endtask

  // one request, sent in bursts with random gaps in between
  task automatic push_req(input logic [1:0] kind, input logic [15:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user <= kind;
    s_data <= pix;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // stop requests and let every owed byte drain, plus the block's tail
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFF - 16'($urandom_range(0, 40));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int eff_size(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // output side pacing, with one long hold-off to back up the block
  initial begin : sink_pacing
    int mode;
    int span;
    int period;
    int n;
    bit held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      period = $urandom_range(2, 5);
      for (n = 0; n < span; n++) begin
        @(posedge clk);
        if (squeeze && !held) begin
          held = 1'b1;
          m_ready <= 1'b0;
          repeat (HOLD_OFF) @(posedge clk);
        end else begin
          case (mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) != 0);
            default: m_ready <= (n % period == 0);
          endcase
        end
      end
    end
  end

  // give up when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("bitmap_upscale_rgb666_stream_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          ew;
    int          eh;
    int          es;
    int          wv;
    int          hv;
    int          sv;
    int          total;
    int          cap;
    int          sent;
    int          k;
    logic [1:0]  kind;
    logic [1:0]  noise;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // no frame yet: pixel, replay and the unused code are dropped
    push_req(REQ_PIXEL, 16'h1234);
    push_req(REQ_REPLAY, 16'hFFFF);
    push_req(REQ_UNUSED, 16'h0000);
    // reset window, one white pixel ends the frame, then a stray replay
    push_req(REQ_START, 16'h0000);
    push_req(REQ_PIXEL, 16'hFFFF);
    push_req(REQ_REPLAY, 16'h5555);
    wait_idle();

    // all-ones origin with zero sizes: end column equals the start, end row wraps and swaps
    set_reg(CFG_ORIGIN_X, 16'hFFFF);
    set_reg(CFG_ORIGIN_Y, 16'hFFFF);
    set_reg(CFG_WIDTH, 16'h0000);
    set_reg(CFG_HEIGHT, 16'h0000);
    set_reg(CFG_SCALE, 16'h0000);
    cfg_valid <= 1'b0;
    push_req(REQ_START, 16'hFFFF);
    push_req(REQ_PIXEL, 16'h0000);
    wait_idle();

    // oversize registers saturate; a second start abandons the frame
    set_reg(CFG_ORIGIN_X, 16'hFF00);
    set_reg(CFG_ORIGIN_Y, 16'h1234);
    set_reg(CFG_WIDTH, 16'h03FF);
    set_reg(CFG_HEIGHT, 16'h03FF);
    set_reg(CFG_SCALE, 16'h000F);
    cfg_valid <= 1'b0;
    push_req(REQ_START, 16'h0000);
    push_req(REQ_PIXEL, 16'hA5C3);
    push_req(REQ_PIXEL, 16'h5A3C);
    push_req(REQ_START, 16'h0000);
    push_req(REQ_PIXEL, 16'h0F0F);
    wait_idle();

    // shrink the frame mid-way: column already past the new width
    set_reg(CFG_WIDTH, 16'd1);
    set_reg(CFG_HEIGHT, 16'd2);
    set_reg(CFG_SCALE, 16'd2);
    cfg_valid <= 1'b0;
    push_req(REQ_PIXEL, 16'h8421);
    push_req(REQ_PIXEL, 16'h1111);
    push_req(REQ_REPLAY, 16'h0000);
    push_req(REQ_REPLAY, 16'h0000);
    push_req(REQ_PIXEL, 16'h7BEF);
    push_req(REQ_REPLAY, 16'h0000);

    // random frames, mostly well formed with a little noise
    while (frame_items < RAND_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 4) == 0 && sh_w != 0 && sh_w <= MAX_WIDTH) begin
        // retune mid-frame; width only shrinks so replays hit written entries
        set_reg(CFG_WIDTH, 16'($urandom_range(1, sh_w)));
        set_reg(CFG_HEIGHT, 16'($urandom_range(1, 3)));
        set_reg(CFG_SCALE, 16'($urandom_range(1, 4)));
        cfg_valid <= 1'b0;
        repeat ($urandom_range(4, 16))
          push_req($urandom_range(0, 1) ? REQ_PIXEL : REQ_REPLAY, 16'($urandom()));
        continue;
      end

      case ($urandom_range(0, 19))
        0: wv = 0;
        1: wv = $urandom_range(513, 1023);
        2: wv = 512;
        default: wv = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 19))
        0: hv = 0;
        1: hv = 1023;
        2: hv = 512;
        default: hv = $urandom_range(1, 3);
      endcase
      case ($urandom_range(0, 9))
        0: sv = 0;
        1: sv = $urandom_range(9, 15);
        2, 3: sv = 8;
        default: sv = $urandom_range(1, 4);
      endcase
      set_reg(CFG_ORIGIN_X, pick_origin());
      set_reg(CFG_ORIGIN_Y, pick_origin());
      set_reg(CFG_WIDTH, 16'(wv));
      set_reg(CFG_HEIGHT, 16'(hv));
      set_reg(CFG_SCALE, 16'(sv));
      cfg_valid <= 1'b0;

      // a stray request ahead of the start
      if ($urandom_range(0, 3) == 0) push_req(2'($urandom_range(1, 3)), 16'($urandom()));

      ew = eff_size(int'(sh_w), MAX_WIDTH);
      eh = eff_size(int'(sh_h), int'(MAX_HEIGHT));
      es = eff_size(int'(sh_s), int'(MAX_SCALE));
      total = ew * eh * es;
      cap = $urandom_range(8, 90);
      push_req(REQ_START, 16'($urandom()));
      if (total >= 10) squeeze <= 1'b1;
      frame_items++;
      sent = 1;

      // pixel pass then scale-1 replay passes per row; large frames are cut short
      for (k = 0; k < total && sent < cap && frame_items < RAND_ITEMS; k++) begin
        kind = ((k / ew) % es == 0) ? REQ_PIXEL : REQ_REPLAY;
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 15) == 0) noise = REQ_START;
          else if ($urandom_range(0, 2) == 0) noise = REQ_UNUSED;
          else noise = (kind == REQ_PIXEL) ? REQ_REPLAY : REQ_PIXEL;
          push_req(noise, 16'($urandom()));
        end
        push_req(kind, 16'($urandom()));
        frame_items++;
        sent++;
      end
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0 && bytes_due == 0) begin
      $display("bitmap_upscale_rgb666_stream_tb: done, clean");
    end else begin
      $display("bitmap_upscale_rgb666_stream_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bup_pkg.sv
rtl/bup_line_store.sv
rtl/bup_ctrl.sv
rtl/bup_emit.sv
rtl/bitmap_upscale_rgb666_stream.sv
rtl/bup_checker.sv
verif/link_byte_checker.sv
verif/bitmap_upscale_rgb666_stream_tb.sv
